[src/aip_pkg.sv]
package aip_pkg;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    BASE_AUTO,
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_t;

  typedef enum logic {
    REG_BASE_MODE,
    REG_MAX_WIDTH
  } cfg_reg_t;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] accumulator;
    logic        is_negative;
    logic        overflow_seen;
    logic        any_digit;
    logic [7:0]  char_count;
    base_t       active_base;
  } parse_state_t;

  typedef struct packed {
    base_t      base_mode;
    logic [7:0] max_width;
  } parse_cfg_t;

  typedef struct packed {
    logic [7:0]  terminator;
    logic        no_digits;
    logic        overflowed;
    logic [63:0] value;
  } parse_result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:         PH_SKIP,
    accumulator:   64'd0,
    is_negative:   1'b0,
    overflow_seen: 1'b0,
    any_digit:     1'b0,
    char_count:    8'd0,
    active_base:   BASE_AUTO
  };

endpackage

[src/ascii_integer_parser_core.sv]
// ASCII integer parser core.
// Input stream: one character per request on s_axis (tdata = char_in,
// 0 marks end of text). Output stream: one parsed number per request on
// m_axis; tdata holds value in bits 63:0 and the terminating character in
// bits 71:64, tuser bit 0 is overflowed and bit 1 is no_digits.
// Leading white space and an optional sign are skipped, the base is taken
// from base_mode (auto, octal, decimal, hex) and max_width limits the
// characters per number. The terminating character is returned with the
// result and is not parsed again.
// A result is registered: the terminating character is first held in the
// input register, then the result is loaded into the result register.
// Throughput: one character per cycle while no result is held waiting on
// m_axis_tready; the digit accumulate path is combinational.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata and takes
// effect at once; write it only while the core is idle.
// Reset clears the parse state, the valid flags of both pipeline registers
// and the configuration (auto base, no width limit). When m_axis_tready is
// low the result is held, the input register stalls and s_axis_tready drops
// once it is full; no request is lost.
module ascii_integer_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // value [63:0], terminator [71:64]
  output logic [1:0]  m_axis_tuser,   // overflowed [0], no_digits [1]
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  aip_pkg::parse_cfg_t    cfg;
  aip_pkg::parse_state_t  st;
  aip_pkg::parse_state_t  st_next;
  aip_pkg::parse_result_t res;
  aip_pkg::parse_result_t out_res;
  logic                   emit;
  logic                   s1_valid;
  logic [7:0]             s1_char;
  logic                   s1_adv;
  logic                   out_valid;
  logic                   out_load;

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign out_load      = s1_adv && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_mode <= aip_pkg::BASE_AUTO;
      cfg.max_width <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        aip_pkg::REG_BASE_MODE: cfg.base_mode <= aip_pkg::base_t'(cfg_wdata[1:0]);
        aip_pkg::REG_MAX_WIDTH: cfg.max_width <= cfg_wdata;
        default:                cfg.max_width <= cfg.max_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_char <= s_axis_tdata;
    end
  end

  aip_step u_step (
    .st      (st),
    .char_in (s1_char),
    .cfg     (cfg),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= aip_pkg::STATE_CLEAR;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.terminator, out_res.value};
  assign m_axis_tuser  = {out_res.no_digits, out_res.overflowed};

`ifndef SYNTHESIS
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (st.phase == aip_pkg::PH_SKIP && !st.any_digit && st.accumulator == 64'd0))
    else $error("parse state not cleared after result");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[63:0] == 64'd0 && !m_axis_tuser[0]))
    else $error("no_digits result with nonzero value or overflow");

  a_overflow_ones: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:0] == '1))
    else $error("overflow result not saturated");

  a_digits_base: assert property (@(posedge clk) disable iff (rst)
    (st.phase == aip_pkg::PH_DIGITS) |-> (st.active_base != aip_pkg::BASE_AUTO))
    else $error("digit phase without a chosen base");
`endif

endmodule

[src/aip_step.sv]
module aip_step (
  input  aip_pkg::parse_state_t  st,
  input  logic [7:0]             char_in,
  input  aip_pkg::parse_cfg_t    cfg,
  output aip_pkg::parse_state_t  st_next,
  output logic                   emit,
  output aip_pkg::parse_result_t res
);

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_CR    = 8'h0d;
  localparam logic [7:0]  CH_PLUS  = 8'h2b;
  localparam logic [7:0]  CH_MINUS = 8'h2d;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [7:0]  CH_UA    = 8'h41;
  localparam logic [7:0]  CH_UZ    = 8'h5a;
  localparam logic [7:0]  CH_LA    = 8'h61;
  localparam logic [7:0]  CH_LZ    = 8'h7a;
  localparam logic [7:0]  CH_UX    = 8'h58;
  localparam logic [7:0]  CH_LX    = 8'h78;
  localparam logic [7:0]  UPPER_OFS = 8'd55;
  localparam logic [7:0]  LOWER_OFS = 8'd87;
  localparam logic [6:0]  NOT_DIGIT = 7'd99;
  localparam logic [63:0] CUTOFF_DEC = 64'd1844674407370955161;
  localparam logic [6:0]  CUTLIM_DEC = 7'd5;

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = c - CH_ZERO;
      end else if (c >= CH_UA && c <= CH_UZ) begin
        t = c - UPPER_OFS;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        t = c - LOWER_OFS;
      end else begin
        t = {1'b0, NOT_DIGIT};
      end
      digit_of = t[6:0];
    end
  endfunction

  function automatic logic [6:0] radix_of(input aip_pkg::base_t b);
    begin
      unique case (b)
        aip_pkg::BASE_OCT: radix_of = 7'd8;
        aip_pkg::BASE_HEX: radix_of = 7'd16;
        default:           radix_of = 7'd10;
      endcase
    end
  endfunction

  logic          is_space;
  logic          proceed;
  logic          digit_step;
  logic [6:0]    dig;
  logic [7:0]    count_inc;
  aip_pkg::base_t base;
  logic          ovf_hit;
  logic [63:0]   acc_scaled;

  assign is_space  = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
  assign dig       = digit_of(char_in);
  assign count_inc = (st.char_count == 8'hff) ? st.char_count : st.char_count + 8'd1;

  always_comb begin
    st_next    = st;
    emit       = 1'b0;
    proceed    = 1'b0;
    digit_step = 1'b0;
    base       = st.active_base;
    ovf_hit    = 1'b0;
    acc_scaled = st.accumulator;

    if (st.phase == aip_pkg::PH_SKIP) begin
      if (char_in == CH_NUL) begin
        emit = 1'b1;
      end else if (!is_space) begin
        st_next.phase = aip_pkg::PH_SIGN;
        if (char_in == CH_MINUS || char_in == CH_PLUS) begin
          st_next.is_negative = (char_in == CH_MINUS);
          st_next.char_count  = count_inc;
        end else begin
          proceed = 1'b1;
        end
      end
    end else if (char_in == CH_NUL ||
                 (cfg.max_width != 8'd0 && st.char_count >= cfg.max_width)) begin
      emit = 1'b1;
    end else begin
      proceed = 1'b1;
    end

    if (proceed) begin
      if (st.phase == aip_pkg::PH_SKIP || st.phase == aip_pkg::PH_SIGN) begin
        if ((cfg.base_mode == aip_pkg::BASE_AUTO || cfg.base_mode == aip_pkg::BASE_HEX) &&
            char_in == CH_ZERO) begin
          st_next.any_digit  = 1'b1;
          st_next.char_count = count_inc;
          st_next.phase      = aip_pkg::PH_ZERO;
        end else begin
          base = (cfg.base_mode == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : cfg.base_mode;
          digit_step = 1'b1;
        end
      end else if (st.phase == aip_pkg::PH_ZERO) begin
        if (char_in == CH_LX || char_in == CH_UX) begin
          st_next.active_base = aip_pkg::BASE_HEX;
          st_next.char_count  = count_inc;
          st_next.phase       = aip_pkg::PH_DIGITS;
        end else begin
          base = (cfg.base_mode == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_OCT
                                                       : aip_pkg::BASE_HEX;
          digit_step = 1'b1;
        end
      end else begin
        digit_step = 1'b1;
      end
    end

    if (digit_step) begin
      st_next.active_base = base;
      st_next.phase       = aip_pkg::PH_DIGITS;
      unique case (base)
        aip_pkg::BASE_OCT: begin
          ovf_hit    = (st.accumulator[63:61] != 3'd0);
          acc_scaled = {st.accumulator[60:0], 3'd0};
        end
        aip_pkg::BASE_HEX: begin
          ovf_hit    = (st.accumulator[63:60] != 4'd0);
          acc_scaled = {st.accumulator[59:0], 4'd0};
        end
        default: begin
          ovf_hit    = (st.accumulator > CUTOFF_DEC) ||
                       (st.accumulator == CUTOFF_DEC && dig > CUTLIM_DEC);
          acc_scaled = {st.accumulator[60:0], 3'd0} + {st.accumulator[62:0], 1'b0};
        end
      endcase
      if (dig >= radix_of(base)) begin
        emit = 1'b1;
      end else begin
        if (st.overflow_seen || ovf_hit) begin
          st_next.overflow_seen = 1'b1;
        end else begin
          st_next.accumulator = acc_scaled + {57'd0, dig};
        end
        st_next.any_digit  = 1'b1;
        st_next.char_count = count_inc;
      end
    end

    if (emit) begin
      st_next = aip_pkg::STATE_CLEAR;
    end
  end

  always_comb begin
    res.terminator = char_in;
    res.overflowed = st.overflow_seen;
    res.no_digits  = !st.any_digit;
    if (st.overflow_seen) begin
      res.value = '1;
    end else if (st.is_negative) begin
      res.value = 64'd0 - st.accumulator;
    end else begin
      res.value = st.accumulator;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

class parse_scoreboard;
  aip_pkg::base_t         mode;
  logic [7:0]             width_limit;
  aip_pkg::phase_t        ph;
  logic [63:0]            acc;
  logic                   neg;
  logic                   ovf;
  logic                   seen_digit;
  logic [7:0]             count;
  aip_pkg::base_t         base;
  aip_pkg::parse_result_t expected_numbers[$];
  int                     mismatches;

  function new();
    mode = aip_pkg::BASE_AUTO;
    width_limit = 8'd0;
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    ph = aip_pkg::PH_SKIP;
    acc = 64'd0;
    neg = 1'b0;
    ovf = 1'b0;
    seen_digit = 1'b0;
    count = 8'd0;
    base = aip_pkg::BASE_AUTO;
  endfunction

  function void write_reg(aip_pkg::cfg_reg_t idx, logic [7:0] val);
    if (idx == aip_pkg::REG_BASE_MODE) begin
      mode = aip_pkg::base_t'(val[1:0]);
    end else begin
      width_limit = val;
    end
  endfunction

  function int pending();
    return expected_numbers.size();
  endfunction

  function void bump();
    if (count != 8'hFF) begin
      count = count + 8'd1;
    end
  endfunction

  function void finish_number(logic [7:0] term);
    aip_pkg::parse_result_t r;
    r.value = ovf ? 64'hFFFF_FFFF_FFFF_FFFF : (neg ? 64'd0 - acc : acc);
    r.overflowed = ovf;
    r.no_digits = !seen_digit;
    r.terminator = term;
    expected_numbers.push_back(r);
    clear();
  endfunction

  function int unsigned digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    if (c >= "a" && c <= "z") return c - "a" + 10;
    return 99;
  endfunction

  // one accepted character request
  function void note_char(logic [7:0] c);
    int unsigned d;
    int unsigned radix;
    logic [63:0] cutoff;
    logic [63:0] cutlim;
    if (ph == aip_pkg::PH_SKIP) begin
      if (c == 8'h00) begin
        finish_number(c);
        return;
      end
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      ph = aip_pkg::PH_SIGN;
      if (c == "-" || c == "+") begin
        neg = (c == "-");
        bump();
        return;
      end
    end else begin
      if (c == 8'h00 || (width_limit != 8'd0 && count >= width_limit)) begin
        finish_number(c);
        return;
      end
    end
    if (ph == aip_pkg::PH_SIGN) begin
      if ((mode == aip_pkg::BASE_AUTO || mode == aip_pkg::BASE_HEX) && c == "0") begin
        seen_digit = 1'b1;
        bump();
        ph = aip_pkg::PH_ZERO;
        return;
      end
      base = (mode == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : mode;
      ph = aip_pkg::PH_DIGITS;
    end else if (ph == aip_pkg::PH_ZERO) begin
      if (c == "x" || c == "X") begin
        base = aip_pkg::BASE_HEX;
        bump();
        ph = aip_pkg::PH_DIGITS;
        return;
      end
      base = (mode == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_OCT : aip_pkg::BASE_HEX;
      ph = aip_pkg::PH_DIGITS;
    end
    radix = (base == aip_pkg::BASE_OCT) ? 8 : (base == aip_pkg::BASE_HEX) ? 16 : 10;
    d = digit_of(c);
    if (d >= radix) begin
      finish_number(c);
      return;
    end
    cutoff = 64'hFFFF_FFFF_FFFF_FFFF / 64'(radix);
    cutlim = 64'hFFFF_FFFF_FFFF_FFFF % 64'(radix);
    if (ovf || acc > cutoff || (acc == cutoff && 64'(d) > cutlim)) begin
      ovf = 1'b1;
    end else begin
      acc = acc * 64'(radix) + 64'(d);
    end
    seen_digit = 1'b1;
    bump();
  endfunction

  function void check_result(aip_pkg::parse_result_t got);
    aip_pkg::parse_result_t want;
    if (expected_numbers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: value %h ovf %0b no_digits %0b term %h",
                 got.value, got.overflowed, got.no_digits, got.terminator);
      end
      return;
    end
    want = expected_numbers.pop_front();
    if (got.value !== want.value || got.overflowed !== want.overflowed ||
        got.no_digits !== want.no_digits || got.terminator !== want.terminator) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected value %h ovf %0b no_digits %0b term %h",
                 want.value, want.overflowed, want.no_digits, want.terminator);
        $display("          got      value %h ovf %0b no_digits %0b term %h",
                 got.value, got.overflowed, got.no_digits, got.terminator);
      end
    end
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT = 5000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;

  parse_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  ascii_integer_parser_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    aip_pkg::parse_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[63:0];
      got.terminator = m_axis_tdata[71:64];
      got.overflowed = m_axis_tuser[0];
      got.no_digits = m_axis_tuser[1];
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_char(c);
  endtask

  task automatic apply_setting(input aip_pkg::base_t mode, input logic [7:0] width);
    cfg_we <= 1'b1;
    cfg_addr <= aip_pkg::REG_BASE_MODE;
    cfg_wdata <= 8'(mode);
    @(posedge clk);
    sb.write_reg(aip_pkg::REG_BASE_MODE, 8'(mode));
    cfg_addr <= aip_pkg::REG_MAX_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    sb.write_reg(aip_pkg::REG_MAX_WIDTH, width);
    cfg_we <= 1'b0;
  endtask

  // close the current number and let the core drain before reconfiguring
  task automatic drain();
    send_char(8'h00);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] digit_char(input int radix);
    int v;
    v = $urandom_range(0, radix - 1);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int n;
    n = $urandom_range(8, 13);
    return (n == 8) ? " " : 8'(n);
  endfunction

  task automatic send_random_number(input aip_pkg::base_t mode, inout int counted);
    logic [7:0] text[$];
    int radix;
    int ndig;
    int nlead;
    nlead = 0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      nlead = $urandom_range(0, 2);
      repeat (nlead) text.push_back(blank_char());
      case ($urandom_range(0, 2))
        1: text.push_back("+");
        2: text.push_back("-");
        default: ;
      endcase
      radix = (mode == aip_pkg::BASE_OCT) ? 8 : (mode == aip_pkg::BASE_HEX) ? 16 : 10;
      if (mode == aip_pkg::BASE_AUTO || mode == aip_pkg::BASE_HEX) begin
        case ($urandom_range(0, 3))
          0: begin
            text.push_back("0");
            text.push_back($urandom_range(0, 1) ? "x" : "X");
            radix = 16;
          end
          1: begin
            text.push_back("0");
            if (mode == aip_pkg::BASE_AUTO) radix = 8;
          end
          default: begin
            if (mode == aip_pkg::BASE_AUTO) text.push_back(8'("1" + $urandom_range(0, 8)));
          end
        endcase
      end
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 12);
      repeat (ndig) begin
        text.push_back(($urandom_range(0, 9) == 0) ? digit_char(16) : digit_char(radix));
      end
      case ($urandom_range(0, 4))
        0: text.push_back(8'h00);
        1: text.push_back(" ");
        2: text.push_back(",");
        3: text.push_back(8'($urandom_range(0, 255)));
        default: text.push_back(digit_char(16));
      endcase
    end
    foreach (text[i]) send_char(text[i]);
    counted += text.size();
  endtask

  initial begin
    aip_pkg::base_t modes [NUM_PHASES];
    logic [7:0]     widths [NUM_PHASES];
    logic [7:0]     directed[$];
    int             counted;
    modes = '{aip_pkg::BASE_HEX, aip_pkg::BASE_OCT, aip_pkg::BASE_DEC, aip_pkg::BASE_AUTO,
              aip_pkg::BASE_HEX, aip_pkg::BASE_DEC, aip_pkg::BASE_OCT, aip_pkg::BASE_AUTO};
    widths = '{8'd255, 8'd1, 8'd0, 8'd5, 8'd0, 8'd20, 8'd3, 8'd0};
    directed = {8'h00, "-", ",", "0", "x", "g", " ", 8'h09, "+", "7", "7", 8'hFF,
                "-", "0", "1", "7", 8'h00, "0", "X", "1", "f", " "};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_setting(aip_pkg::BASE_AUTO, 8'd0);
    foreach (directed[i]) send_char(directed[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(modes[p], widths[p]);
      calm = ($urandom_range(0, 3) == 0);
      if (p == 1) hold_off = 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) send_random_number(modes[p], counted);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
